/* rtl/core/mbrc_pkg.sv */
// Package for the Modbus RTU read-response checker: codes, constants, payload types
// and the CRC-16/MODBUS byte step. No dependencies.
`default_nettype none

package mbrc_pkg;

   localparam int unsigned MAX_FRAME = 256;
   localparam logic [9:0]  MAX_FRAME_LEN = 10'(MAX_FRAME);
   localparam logic [9:0]  FRAME_OVERHEAD = 10'd5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0]  FUNC_READ      = 8'h03;
   localparam logic [7:0]  FUNC_EXCEPTION = 8'h83;

   localparam logic        CMD_ARM  = 1'b0;
   localparam logic        CMD_BYTE = 1'b1;

   // byte positions inside a reply frame
   localparam logic [8:0]  POS_ADDRESS   = 9'd0;
   localparam logic [8:0]  POS_FUNCTION  = 9'd1;
   localparam logic [8:0]  POS_COUNT     = 9'd2;
   localparam logic [8:0]  POS_EXC_END   = 9'd4;
   localparam logic [8:0]  POS_WORD_LAST = 9'd6;

   typedef enum logic [2:0] {
      STATUS_BUSY      = 3'd0,
      STATUS_OK        = 3'd1,
      STATUS_EXCEPTION = 3'd2,
      STATUS_CRC_ERROR = 3'd3,
      STATUS_IGNORED   = 3'd4,
      STATUS_TOO_LONG  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PHASE_IDLE   = 4'b0001,
      PHASE_RECV   = 4'b0010,
      PHASE_IGNORE = 4'b0100,
      PHASE_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] slave_address;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] raw_value;
      logic [7:0]  data_byte_count;
   } result_type;

   // one reflected CRC-16 byte update
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mbrc_if.sv */
// Valid/ready channel interfaces for request and response of the checker.
// Depends on mbrc_pkg.
`default_nettype none

interface mbrc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] slave_address;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output slave_address, output rx_byte,
                   input ready);
   modport sink (input valid, input cmd, input slave_address, input rx_byte,
                 output ready);
endinterface

interface mbrc_rsp_if;
   logic                valid;
   logic                ready;
   mbrc_pkg::status_type status;
   logic [31:0]         raw_value;
   logic [7:0]          data_byte_count;

   modport source (output valid, output status, output raw_value, output data_byte_count,
                   input ready);
   modport sink (input valid, input status, input raw_value, input data_byte_count,
                 output ready);
endinterface

`default_nettype wire

/* rtl/core/modbus_read_response_checker.sv */
// Top level of the Modbus RTU read-holding-registers reply checker.
// Depends on mbrc_pkg, mbrc_req_if / mbrc_rsp_if and mbrc_frame_core.
//
// Feed one request per received byte (cmd 1) after arming with the expected
// slave address (cmd 0); every request yields exactly one response, in order.
// Status 0 means the frame is still in progress; 1 (ok, with raw_value holding
// bytes 3..6 little-endian and data_byte_count the count field), 2 (exception
// reply on its fifth byte), 3 (CRC mismatch), 5 (count too large for MAX_FRAME)
// end the frame; 4 means the byte was ignored (wrong address, unknown function,
// or no armed frame). Until the next arm, further bytes answer 4. The block
// takes one request every clock cycle while the response is not stalled. An
// accepted request is held in the input register, then passes through the
// CRC-16 byte step and frame decision into the response register. A stalled
// response holds the input register, so at most two requests are in flight.
// The CRC byte step is the longest path.
`default_nettype none

module modbus_read_response_checker (
   input wire logic clock,
   input wire logic reset,
   mbrc_req_if.sink   req_chan,
   mbrc_rsp_if.source rsp_chan
);
   import mbrc_pkg::*;

   logic       in_valid_ff;
   req_type    in_item_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type core_result;
   logic       advance;

   // advance the held request whenever the response register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // hold the accepted request for the decision stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.cmd           <= req_chan.cmd;
         in_item_ff.slave_address <= req_chan.slave_address;
         in_item_ff.rx_byte       <= req_chan.rx_byte;
      end
   end

   // frame state updates only when the request moves into the response register
   mbrc_frame_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_result_ff.status;
   assign rsp_chan.raw_value       = out_result_ff.raw_value;
   assign rsp_chan.data_byte_count = out_result_ff.data_byte_count;

endmodule

`default_nettype wire

/* rtl/core/mbrc_frame_core.sv */
// Frame tracking state and per-byte decision logic of the reply checker.
// Depends on mbrc_pkg.
`default_nettype none

module mbrc_frame_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire mbrc_pkg::req_type    item,
   output      mbrc_pkg::result_type result
);
   import mbrc_pkg::*;

   logic [7:0]  expected_address_ff, expected_address_in;
   logic [8:0]  position_ff, position_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  function_seen_ff, function_seen_in;
   logic [7:0]  count_seen_ff, count_seen_in;
   logic [31:0] captured_word_ff, captured_word_in;
   logic [7:0]  crc_low_seen_ff, crc_low_seen_in;
   phase_type   phase_ff, phase_in;

   logic [15:0] crc_next;
   logic [8:0]  crc_low_pos;
   logic [4:0]  word_shift;
   logic [31:0] word_merged;

   assign crc_next    = crc_byte(running_crc_ff, item.rx_byte);
   assign crc_low_pos = {1'b0, count_seen_ff} + 9'd3;
   assign word_shift  = {position_ff[1:0] + 2'd1, 3'b000};
   assign word_merged = captured_word_ff | ({24'h000000, item.rx_byte} << word_shift);

   always_comb begin
      expected_address_in = expected_address_ff;
      position_in         = position_ff;
      running_crc_in      = running_crc_ff;
      function_seen_in    = function_seen_ff;
      count_seen_in       = count_seen_ff;
      captured_word_in    = captured_word_ff;
      crc_low_seen_in     = crc_low_seen_ff;
      phase_in            = phase_ff;
      result.status          = STATUS_BUSY;
      result.raw_value       = 32'h0;
      result.data_byte_count = 8'h00;

      if (item.cmd == CMD_ARM) begin
         expected_address_in = item.slave_address;
         position_in         = 9'd0;
         running_crc_in      = CRC_INIT;
         function_seen_in    = 8'h00;
         count_seen_in       = 8'h00;
         captured_word_in    = 32'h0;
         crc_low_seen_in     = 8'h00;
         phase_in            = PHASE_RECV;
      end else if (phase_ff != PHASE_RECV) begin
         result.status = STATUS_IGNORED;
      end else begin
         if (position_ff == POS_ADDRESS) begin
            if (item.rx_byte != expected_address_ff) begin
               phase_in      = PHASE_IGNORE;
               result.status = STATUS_IGNORED;
            end else begin
               running_crc_in = crc_next;
            end
         end else if (position_ff == POS_FUNCTION) begin
            function_seen_in = item.rx_byte;
            if (item.rx_byte inside {FUNC_READ, FUNC_EXCEPTION}) begin
               running_crc_in = crc_next;
            end else begin
               phase_in      = PHASE_IGNORE;
               result.status = STATUS_IGNORED;
            end
         end else if (position_ff == POS_COUNT) begin
            count_seen_in  = item.rx_byte;
            running_crc_in = crc_next;
            if (function_seen_ff == FUNC_READ &&
                ({2'b00, item.rx_byte} + FRAME_OVERHEAD) > MAX_FRAME_LEN) begin
               phase_in      = PHASE_DONE;
               result.status = STATUS_TOO_LONG;
            end
         end else if (function_seen_ff == FUNC_EXCEPTION) begin
            if (position_ff >= POS_EXC_END) begin
               phase_in      = PHASE_DONE;
               result.status = STATUS_EXCEPTION;
            end
         end else begin
            // data bytes, then CRC low, then CRC high
            if (position_ff <= POS_WORD_LAST) begin
               captured_word_in = word_merged;
            end
            if (position_ff < crc_low_pos) begin
               running_crc_in = crc_next;
            end else if (position_ff == crc_low_pos) begin
               crc_low_seen_in = item.rx_byte;
            end else begin
               phase_in = PHASE_DONE;
               if ({item.rx_byte, crc_low_seen_ff} == running_crc_ff) begin
                  result.status          = STATUS_OK;
                  result.raw_value       = captured_word_in;
                  result.data_byte_count = count_seen_ff;
               end else begin
                  result.status = STATUS_CRC_ERROR;
               end
            end
         end
         if (phase_in == PHASE_RECV) begin
            position_in = position_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_address_ff <= 8'h00;
         position_ff         <= 9'd0;
         running_crc_ff      <= CRC_INIT;
         function_seen_ff    <= 8'h00;
         count_seen_ff       <= 8'h00;
         captured_word_ff    <= 32'h0;
         crc_low_seen_ff     <= 8'h00;
         phase_ff            <= PHASE_IDLE;
      end else if (step) begin
         expected_address_ff <= expected_address_in;
         position_ff         <= position_in;
         running_crc_ff      <= running_crc_in;
         function_seen_ff    <= function_seen_in;
         count_seen_ff       <= count_seen_in;
         captured_word_ff    <= captured_word_in;
         crc_low_seen_ff     <= crc_low_seen_in;
         phase_ff            <= phase_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mbrc_checker.sv */
// Port-level assertions for the reply checker, bound to the top level.
// Depends on mbrc_pkg and modbus_read_response_checker.
`default_nettype none

module mbrc_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire mbrc_pkg::status_type rsp_status,
   input wire logic [31:0]          rsp_raw_value,
   input wire logic [7:0]           rsp_data_byte_count
);
   import mbrc_pkg::*;

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // only an ok frame carries a value and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_raw_value == 32'h0 &&
                                               rsp_data_byte_count == 8'h00)
      else $error("payload on a non-ok response");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

   // an empty response stage never blocks an offered request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request stalled with empty response stage");

endmodule

bind modbus_read_response_checker mbrc_checker u_mbrc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_raw_value       (rsp_chan.raw_value),
   .rsp_data_byte_count (rsp_chan.data_byte_count)
);

`default_nettype wire
